@@ rtl/address_pool_allocator_assert.svh @@
// Assertion macros used by the allocator's checker.
`ifndef ADDRESS_POOL_ALLOCATOR_ASSERT_SVH
`define ADDRESS_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define APA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("address pool allocator check failed");

// Next-cycle implication, disabled while reset is held.
`define APA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("address pool allocator check failed");

`endif

@@ rtl/apa_pkg.sv @@
`default_nettype none

package apa_pkg;

    localparam int unsigned ID_BITS   = 16;
    localparam int unsigned PTR_W     = ID_BITS + 1;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned RING_DEPTH = 2 ** ID_BITS;
    localparam int unsigned CFG_AW    = 3;

    localparam logic [PTR_W-1:0] ID_LIMIT = {1'b1, {ID_BITS{1'b0}}};
    localparam logic [PTR_W-1:0] ID_MASK  = {1'b0, {ID_BITS{1'b1}}};

    // Register index as seen in paddr[CFG_AW-1]
    localparam logic REG_PREFIX = 1'b0;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RECYCLE = 1'b1;

    typedef struct packed {
        logic exec;       // accept the request, update pointers
        logic load_ring;  // registered ring data is valid, form result
        logic emit;       // move the pending result into the output register
    } cmd_t;

    typedef struct packed {
        logic ring_pop;   // request pops the free ring
    } status_t;

    function automatic logic [ADDR_W-1:0] swap_bytes(input logic [ADDR_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/apa_ram.sv @@
`default_nettype none

module apa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/apa_ctrl.sv @@
`default_nettype none

module apa_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire apa_pkg::status_t status,
    output apa_pkg::cmd_t         cmd
);

    import apa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cmd.exec      = accept;
    assign cmd.load_ring = (state_reg == S_READ);
    assign cmd.emit      = (state_reg == S_EMIT) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = status.ring_pop ? S_READ : S_EMIT;
                end
            end
            S_READ: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load on emit, drop once the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

@@ rtl/apa_datapath.sv @@
`default_nettype none

module apa_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire apa_pkg::cmd_t               cmd,
    output apa_pkg::status_t                 status,
    input  wire logic [apa_pkg::ADDR_W-1:0]  s_tdata,
    input  wire logic [0:0]                  s_tuser,
    input  wire logic                        cfg_we,
    input  wire logic [apa_pkg::ADDR_W-1:0]  cfg_wdata,
    output logic      [apa_pkg::ADDR_W-1:0]  prefix,
    output logic      [apa_pkg::ADDR_W-1:0]  m_tdata,
    output logic      [0:0]                  m_tuser
);

    import apa_pkg::*;

    logic [ADDR_W-1:0]  prefix_reg, prefix_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W-1:0]   hw_reg, hw_next;
    logic               res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               out_ok_reg;
    logic [ADDR_W-1:0]  out_addr_reg;

    logic [PTR_W-1:0]   count;
    logic               ring_empty;
    logic               ring_full;
    logic               ring_last;
    logic               is_alloc;
    logic [ADDR_W-1:0]  host;
    logic [ADDR_W-1:0]  off;
    logic               off_ok;
    logic [PTR_W-1:0]   hw_inc;
    logic               push;
    logic [ID_BITS-1:0] ring_rdata;

    assign count      = tail_reg - head_reg;
    assign ring_empty = (count == '0);
    assign ring_full  = (count == ID_LIMIT);
    assign ring_last  = (count == ID_MASK);
    assign is_alloc   = (s_tuser[0] == OP_ALLOC);

    assign host   = swap_bytes(s_tdata);
    assign off    = host - prefix_reg;
    // Offset must be nonzero, inside the id space and not above the high-water mark
    assign off_ok = (host >= prefix_reg) && (off != '0) &&
                    (off[ADDR_W-1:ID_BITS] == '0) && (off[PTR_W-1:0] <= hw_reg);
    assign hw_inc = hw_reg + PTR_W'(1);

    assign push = cmd.exec && !is_alloc && off_ok && !ring_full;

    assign status.ring_pop = is_alloc && !ring_empty;

    apa_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (tail_reg[ID_BITS-1:0]),
        .wr_data (off[ID_BITS-1:0]),
        .rd_en   (cmd.exec && status.ring_pop),
        .rd_addr (head_reg[ID_BITS-1:0]),
        .rd_data (ring_rdata)
    );

    always_comb begin
        prefix_next   = prefix_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        hw_next       = hw_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;

        if (cfg_we) begin
            prefix_next = cfg_wdata;
        end

        if (cmd.exec) begin
            res_ok_next   = 1'b0;
            res_addr_next = '0;
            if (is_alloc) begin
                priority if (!ring_empty) begin
                    // result is formed once the ring data returns
                    head_next = head_reg + PTR_W'(1);
                end else if (hw_reg < ID_MASK) begin
                    hw_next       = hw_inc;
                    res_ok_next   = 1'b1;
                    res_addr_next = swap_bytes(prefix_reg + ADDR_W'(hw_inc));
                end else begin
                    res_ok_next = 1'b0;
                end
            end else if (push) begin
                res_ok_next = 1'b1;
                if (ring_last) begin
                    // ring fills: return the whole pool to its reset state
                    head_next = '0;
                    tail_next = '0;
                    hw_next   = '0;
                end else begin
                    tail_next = tail_reg + PTR_W'(1);
                end
            end
        end

        if (cmd.load_ring) begin
            res_ok_next   = 1'b1;
            res_addr_next = swap_bytes(prefix_reg + ADDR_W'(ring_rdata));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            hw_reg     <= '0;
        end else begin
            prefix_reg <= prefix_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            hw_reg     <= hw_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        if (cmd.emit) begin
            out_ok_reg   <= res_ok_reg;
            out_addr_reg <= res_addr_reg;
        end
    end

    assign prefix     = prefix_reg;
    assign m_tdata    = out_addr_reg;
    assign m_tuser[0] = out_ok_reg;

endmodule

`default_nettype wire

@@ rtl/address_pool_allocator.sv @@
// A request's result is registered in the result register, then moved into the output register in S_EMIT;
// a pop from the ring first passes the registered read port of the free-list RAM (S_READ). A new
// request is taken only once the previous result has moved into the output register.
// One request is in flight at a time; a finished result waits in the output register.
// Reset (aresetn low, synchronous) clears prefix, ring pointers and high-water mark;
// free-list RAM contents are not cleared.
`default_nettype none

module address_pool_allocator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // request channel
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [apa_pkg::ADDR_W-1:0]  s_tdata,   // [31:0] addr_in
    input  wire logic [0:0]                  s_tuser,   // [0] operation
    // result channel
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [apa_pkg::ADDR_W-1:0]  m_tdata,   // [31:0] addr_out
    output logic      [0:0]                  m_tuser,   // [0] ok
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [apa_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    import apa_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              cfg_we;
    logic [ADDR_W-1:0] prefix;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[CFG_AW-1] == REG_PREFIX);
    assign prdata = (paddr[CFG_AW-1] == REG_PREFIX) ? prefix : '0;

    apa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    apa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata),
        .prefix    (prefix),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ rtl/apa_checker.sv @@
`default_nettype none

`include "address_pool_allocator_assert.svh"

module apa_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [apa_pkg::ADDR_W-1:0]  m_tdata,
    input  wire logic [0:0]                  m_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [apa_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    input  wire logic [31:0]                 prdata,
    input  wire logic                        pready
);

    import apa_pkg::*;

    // a stalled result holds
    `APA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // failed requests carry a zero address
    `APA_ASSERT_SAME(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser[0] == 1'b0),
        m_tdata == '0)

    // one request at a time: no transfer in the cycle after a transfer
    `APA_ASSERT_NEXT(a_one_inflight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a result never appears the cycle right after its request
    `APA_ASSERT_SAME(a_min_latency, aclk, aresetn, $rose(m_tvalid),
        !$past(s_tvalid && s_tready))

    // prefix reads back what was written
    `APA_ASSERT_NEXT(a_prefix_rb, aclk, aresetn,
        psel && penable && pwrite && pready && (paddr[CFG_AW-1] == REG_PREFIX),
        (paddr[CFG_AW-1] != REG_PREFIX) || (prdata == $past(pwdata)))

endmodule

bind address_pool_allocator apa_checker u_apa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

`default_nettype wire
